### src/bmc_pkg.sv
// Shared types and constants of the belt move controller.
package bmc_pkg;

   // Request kinds carried in req_tuser.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_POWER = 2'd1,
      OP_MOVE  = 2'd2
   } op_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MAX_SPEED    = 2'd0,
      CSR_TRAVEL_LIMIT = 2'd1,
      CSR_STEPWISE     = 2'd2
   } csr_index_type;

   localparam int SPEED_W = 24;
   localparam int LIMIT_W = 31;
   localparam int POS_W   = 32;
   localparam int OUT_SPEED_W = 25;
   localparam int POWER_W = 7;
   localparam int QUOT_W  = 18;

   localparam int ARRIVE_TOL   = 500;
   localparam int MIN_DISTANCE = 100;
   localparam int POWER_MAX    = 100;

   localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 24'd1000000;
   localparam logic [LIMIT_W-1:0] LIMIT_RST     = 31'd1000000;

   // floor(x / 100) for x below 2**24 is (x * DIV100_M24) >> DIV100_S24.
   localparam logic [24:0] DIV100_M24 = 25'd21474837;
   localparam int          DIV100_S24 = 31;
   // floor(y / 100) for y below 10000 is (y * DIV100_M14) >> DIV100_S14.
   localparam logic [12:0] DIV100_M14 = 13'd5243;
   localparam int          DIV100_S14 = 19;

endpackage

### src/belt_move_controller.sv
// Belt move controller: request decode, move state and registered response.
// Latency: the response to a request is valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless a response is held; all work is one combinational
// pass from the request ports into the response register and the state registers.
// The request side stays ready while a held response is being taken in the same cycle.
// Reset (synchronous, active high) stops any move, zeroes power and loads the register
// defaults: full speed 1000000 um/s, travel limit 1000000 um, plain moves.
module belt_move_controller
   import bmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] belt_position, [63:32] command_value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [24:0] speed_command, [25] zero_position, [26] accepted, [27] moving,
   // [34:28] power_level, [35] running, [39:36] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [30:0] csr_wdata
);

   // Configuration. The full speed is also kept split as 100*q + r so that a power
   // command needs only small products.
   logic [SPEED_W-1:0] max_speed_ff;
   logic [QUOT_W-1:0]  speed_quot_ff;
   logic [POWER_W-1:0] speed_rem_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               stepwise_ff;

   // Controller state.
   logic [SPEED_W-1:0]   free_speed_ff,  free_speed_in;
   logic [POWER_W-1:0]   power_ff,       power_in;
   logic                 busy_ff,        busy_in;
   logic [LIMIT_W-1:0]   target_ff,      target_in;
   logic [POS_W-1:0]     dist_left_ff,   dist_left_in;
   logic [SPEED_W-2:0]   move_speed_ff,  move_speed_in;

   // Response register.
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic [POS_W-1:0]          pos;
   logic [POS_W-1:0]          cmd;
   logic signed [POS_W:0]     tgt_diff;
   logic                      near;
   logic [POS_W-1:0]          abs_pos;
   logic signed [POS_W+1:0]   dist_diff;
   logic [POS_W:0]            plain_sum;
   logic [LIMIT_W-1:0]        plain_tgt;
   logic signed [POS_W+1:0]   plain_diff;
   logic                      plain_far;
   logic                      cmd_power_ok;
   logic                      cmd_move_ok;
   logic [POWER_W-1:0]        cmd_pct;
   logic [24:0]               quot_prod;
   logic [13:0]               rem_prod;
   logic [26:0]               rem_scaled;
   logic [24:0]               power_speed;
   logic [48:0]               cfg_prod;
   logic [QUOT_W-1:0]         cfg_quot;
   logic [SPEED_W-1:0]        cfg_hundreds;
   logic [SPEED_W-1:0]        cfg_rem;
   logic signed [OUT_SPEED_W-1:0] speed_out;
   logic                      zero_out;
   logic                      acc_out;

   assign pos     = req_tdata[31:0];
   assign cmd     = req_tdata[63:32];
   assign accept  = req_tvalid && req_tready;

   // A new request may enter whenever the response slot is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Split of a newly written full speed by 100, done with a reciprocal multiply.
   assign cfg_prod     = 49'(csr_wdata[SPEED_W-1:0]) * 49'(DIV100_M24);
   assign cfg_quot     = cfg_prod[DIV100_S24 +: QUOT_W];
   assign cfg_hundreds = SPEED_W'(cfg_quot * SPEED_W'(POWER_MAX));
   assign cfg_rem      = csr_wdata[SPEED_W-1:0] - cfg_hundreds;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= MAX_SPEED_RST;
         speed_quot_ff <= QUOT_W'(MAX_SPEED_RST / POWER_MAX);
         speed_rem_ff  <= POWER_W'(MAX_SPEED_RST % POWER_MAX);
         limit_ff      <= LIMIT_RST;
         stepwise_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_MAX_SPEED: begin
               max_speed_ff  <= csr_wdata[SPEED_W-1:0];
               speed_quot_ff <= cfg_quot;
               speed_rem_ff  <= cfg_rem[POWER_W-1:0];
            end
            CSR_TRAVEL_LIMIT: begin
               limit_ff <= csr_wdata;
            end
            CSR_STEPWISE: begin
               stepwise_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Distance from the measured position to the current target; within the
   // tolerance band the belt counts as arrived.
   assign tgt_diff = signed'({pos[POS_W-1], pos} - {2'b00, target_ff});
   assign near     = (tgt_diff > -33'(ARRIVE_TOL)) && (tgt_diff < 33'(ARRIVE_TOL));
   assign abs_pos  = pos[POS_W-1] ? (~pos + 32'd1) : pos;

   // Remaining distance of a segmented move after this segment.
   assign dist_diff = signed'({{2{dist_left_ff[POS_W-1]}}, dist_left_ff} -
                              {2'b00, abs_pos});

   // Plain move: target is position plus distance, clamped to the travel range.
   assign plain_sum = {pos[POS_W-1], pos} + {cmd[POS_W-1], cmd};
   always_comb begin
      if (plain_sum[POS_W]) begin
         plain_tgt = '0;
      end else if (plain_sum > {2'b00, limit_ff}) begin
         plain_tgt = limit_ff;
      end else begin
         plain_tgt = plain_sum[LIMIT_W-1:0];
      end
   end
   assign plain_diff = signed'({{2{pos[POS_W-1]}}, pos} - {3'b000, plain_tgt});
   assign plain_far  = (plain_diff >= 34'(ARRIVE_TOL)) || (plain_diff <= -34'(ARRIVE_TOL));

   // Power scaling: max*p/100 = q*p + floor(r*p/100) with max = 100*q + r.
   assign cmd_power_ok = !cmd[POS_W-1] && (cmd <= 32'(POWER_MAX));
   assign cmd_move_ok  = !cmd[POS_W-1] && (cmd > 32'(MIN_DISTANCE));
   assign cmd_pct      = cmd[POWER_W-1:0];
   assign quot_prod    = 25'(speed_quot_ff * cmd_pct);
   assign rem_prod     = 14'(speed_rem_ff * cmd_pct);
   assign rem_scaled   = 27'(rem_prod * DIV100_M14);
   assign power_speed  = quot_prod + 25'(rem_scaled[26:DIV100_S14]);

   always_comb begin
      free_speed_in = free_speed_ff;
      power_in      = power_ff;
      busy_in       = busy_ff;
      target_in     = target_ff;
      dist_left_in  = dist_left_ff;
      move_speed_in = move_speed_ff;
      speed_out     = '0;
      zero_out      = 1'b0;
      acc_out       = 1'b0;
      case (op_type'(req_tuser))
         OP_TICK: begin
            if (!busy_ff) begin
               speed_out = signed'({1'b0, free_speed_ff});
            end else if (near) begin
               zero_out = 1'b1;
               if (!stepwise_ff) begin
                  busy_in = 1'b0;
               end else if (dist_diff <= 34'(ARRIVE_TOL)) begin
                  // Move done. Anything at or below the tolerance behaves the same
                  // later on, so a very negative rest is held at the lowest value.
                  busy_in = 1'b0;
                  if (dist_diff < -34'sh80000000) begin
                     dist_left_in = 32'h80000000;
                  end else begin
                     dist_left_in = dist_diff[POS_W-1:0];
                  end
               end else begin
                  dist_left_in = dist_diff[POS_W-1:0];
                  if (dist_diff[LIMIT_W-1:0] < limit_ff) begin
                     target_in = dist_diff[LIMIT_W-1:0];
                  end else begin
                     target_in = limit_ff;
                  end
               end
            end else if (tgt_diff < 0) begin
               // Target lies above the position.
               speed_out = signed'({2'b00, move_speed_ff});
            end else begin
               speed_out = -signed'({2'b00, move_speed_ff});
            end
         end
         OP_POWER: begin
            if (cmd_power_ok) begin
               power_in      = cmd_pct;
               free_speed_in = power_speed[SPEED_W-1:0];
               busy_in       = 1'b0;
               acc_out       = 1'b1;
            end
         end
         OP_MOVE: begin
            if (cmd_move_ok) begin
               if (stepwise_ff) begin
                  dist_left_in  = cmd;
                  move_speed_in = max_speed_ff[SPEED_W-1:1];
                  free_speed_in = '0;
                  busy_in       = 1'b1;
                  target_in     = (cmd[LIMIT_W-1:0] < limit_ff) ? cmd[LIMIT_W-1:0] : limit_ff;
                  acc_out       = 1'b1;
               end else begin
                  // The target is rewritten even when the move is refused.
                  target_in = plain_tgt;
                  if (plain_far) begin
                     move_speed_in = max_speed_ff[SPEED_W-1:1];
                     busy_in       = 1'b1;
                     free_speed_in = '0;
                     acc_out       = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp_data_in = {4'b0000, (power_in != '0) || busy_in, power_in, busy_in,
                     acc_out, zero_out, speed_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_speed_ff <= '0;
         power_ff      <= '0;
         busy_ff       <= 1'b0;
         target_ff     <= '0;
         dist_left_ff  <= '0;
         move_speed_ff <= '0;
      end else if (accept) begin
         free_speed_ff <= free_speed_in;
         power_ff      <= power_in;
         busy_ff       <= busy_in;
         target_ff     <= target_in;
         dist_left_ff  <= dist_left_in;
         move_speed_ff <= move_speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A moving belt always reports itself as running.
   a_moving_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[27] || rsp_tdata[35]))
      else $error("moving reported without running");

   // A zeroing response never asks for motion.
   a_zero_still: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> (rsp_tdata[24:0] == '0))
      else $error("zero_position with nonzero speed");

   // A tick is never reported as an accepted command.
   a_tick_not_acc: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_TICK)) |=> (rsp_tvalid && !rsp_tdata[26]))
      else $error("tick reported as accepted");

   // Power level stays in its percent range.
   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:28] <= 7'(POWER_MAX)))
      else $error("power level out of range");

   // An accepted power command cancels any move.
   a_power_cancels: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_POWER) && cmd_power_ok) |=> !busy_ff)
      else $error("move still active after power command");

endmodule

### sim/testbench.sv
// Self-checking testbench for the belt move controller: response model, stimulus and checks.
`timescale 1ns / 100ps

module testbench
   import bmc_pkg::*;
();

   // One expected response, field by field, at the widths of the response port.
   typedef struct {
      logic [24:0] speed;
      logic        zero;
      logic        accepted;
      logic        moving;
      logic [6:0]  power;
      logic        running;
   } belt_response_type;

   // Tracks the controller's registers and move state and predicts the response to every
   // accepted request. Predictions wait in order until the matching response comes back.
   class belt_model_type;
      logic [23:0]  max_speed;
      logic [30:0]  travel_limit;
      logic         stepwise;
      logic [23:0]  free_speed;
      logic [6:0]   power_setting;
      logic         busy;
      longint       target;
      longint       distance_left;
      logic [23:0]  move_speed;
      belt_response_type expected_responses[$];
      int           errors;
      int           arrivals;
      int           accepts;

      function new();
         max_speed     = MAX_SPEED_RST;
         travel_limit  = LIMIT_RST;
         stepwise      = 1'b0;
         free_speed    = '0;
         power_setting = '0;
         busy          = 1'b0;
         target        = 0;
         distance_left = 0;
         move_speed    = '0;
         errors        = 0;
         arrivals      = 0;
         accepts       = 0;
      endfunction

      static function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function void set_register(csr_index_type idx, logic [30:0] value);
         case (idx)
            CSR_MAX_SPEED: begin
               max_speed = value[23:0];
            end
            CSR_TRAVEL_LIMIT: begin
               travel_limit = value;
            end
            CSR_STEPWISE: begin
               stepwise = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] pos_bits,
                                 logic [31:0] cmd_bits);
         longint            pos;
         longint            cmd;
         longint            lim;
         longint            speed;
         longint            goal;
         belt_response_type r;
         pos        = $signed(pos_bits);
         cmd        = $signed(cmd_bits);
         lim        = travel_limit;
         speed      = 0;
         r.zero     = 1'b0;
         r.accepted = 1'b0;
         case (op)
            OP_TICK: begin
               if (!busy) begin
                  speed = free_speed;
               end else if (magnitude(pos - target) < ARRIVE_TOL) begin
                  // Arrived: stop and zero the position. A stepwise move either ends or
                  // aims at the next segment.
                  r.zero = 1'b1;
                  if (stepwise) begin
                     distance_left -= magnitude(pos);
                     if (distance_left <= ARRIVE_TOL) begin
                        busy = 1'b0;
                     end else begin
                        target = (distance_left < lim) ? distance_left : lim;
                     end
                  end else begin
                     busy = 1'b0;
                  end
               end else begin
                  speed = (target > pos) ? longint'(move_speed) : -longint'(move_speed);
               end
            end
            OP_POWER: begin
               if (cmd >= 0 && cmd <= POWER_MAX) begin
                  power_setting = cmd[6:0];
                  free_speed    = 24'((longint'(max_speed) * cmd) / POWER_MAX);
                  busy          = 1'b0;
                  r.accepted    = 1'b1;
               end
            end
            OP_MOVE: begin
               if (cmd > MIN_DISTANCE) begin
                  if (stepwise) begin
                     distance_left = cmd;
                     target        = (cmd < lim) ? cmd : lim;
                     move_speed    = max_speed >> 1;
                     free_speed    = '0;
                     busy          = 1'b1;
                     r.accepted    = 1'b1;
                  end else begin
                     goal = pos + cmd;
                     if (goal < 0) goal = 0;
                     if (goal > lim) goal = lim;
                     // The target is rewritten even when the move itself is refused.
                     target = goal;
                     if (magnitude(pos - goal) >= ARRIVE_TOL) begin
                        move_speed = max_speed >> 1;
                        free_speed = '0;
                        busy       = 1'b1;
                        r.accepted = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         r.speed   = speed[24:0];
         r.moving  = busy;
         r.power   = power_setting;
         r.running = (power_setting != 0) || busy;
         expected_responses.push_back(r);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [39:0] data);
         belt_response_type want;
         if (expected_responses.size() == 0) begin
            $error("response arrived with no request outstanding: %h", data);
            errors++;
            return;
         end
         want = expected_responses.pop_front();
         if (data[25]) arrivals++;
         if (data[26]) accepts++;
         compare_field("speed_command", $signed(want.speed), $signed(data[24:0]));
         compare_field("zero_position", want.zero, data[25]);
         compare_field("accepted", want.accepted, data[26]);
         compare_field("moving", want.moving, data[27]);
         compare_field("power_level", want.power, data[34:28]);
         compare_field("running", want.running, data[35]);
      endfunction
   endclass

   // Request kind that the block must ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int PHASES        = 13;
   localparam int PHASE_ITEMS   = 100;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] belt_position, [63:32] command_value
   logic [1:0]  req_tuser  = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [24:0] speed_command, [25] zero_position, [26] accepted, [27] moving,
   // [34:28] power_level, [35] running, [39:36] zero
   logic [39:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [30:0] csr_wdata  = '0;

   belt_model_type belt = new();

   // Idling on either side is switched per phase so that some phases run back to back.
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;
   int op_count[4];
   int settings_count = 1;

   belt_move_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap lengths: mostly none or short, now and then a long pause.
   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one request and hold it until the block takes it. Signals are sampled right
   // after the edge, before any register update of that edge is visible. The valid is only
   // lowered when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic [1:0] op, input logic [31:0] pos,
                               input logic [31:0] cmd);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {cmd, pos};
      do @(posedge clock); while (!req_tready);
      belt.note_request(op, pos, cmd);
      op_count[op]++;
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every outstanding response has been taken, plus the block's latency.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (belt.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Registers change only with the block idle; all three are written each time.
   task automatic program_registers(input logic [23:0] speed_max, input logic [30:0] limit,
                                    input logic step_mode);
      drain_responses();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MAX_SPEED;
      csr_wdata <= 31'(speed_max);
      @(posedge clock);
      belt.set_register(CSR_MAX_SPEED, 31'(speed_max));
      csr_addr  <= CSR_TRAVEL_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      belt.set_register(CSR_TRAVEL_LIMIT, limit);
      csr_addr  <= CSR_STEPWISE;
      csr_wdata <= 31'(step_mode);
      @(posedge clock);
      belt.set_register(CSR_STEPWISE, 31'(step_mode));
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // One random request, shaped after the current move state. While a move is active most
   // requests are ticks, and many of them land inside the arrival window so that plain and
   // stepwise moves run through to their end. Full-width values keep every bit toggling.
   task automatic random_request(output bit counted);
      int         r;
      int         r2;
      logic [1:0] op;
      longint     pos;
      longint     cmd;
      r = $urandom_range(0, 99);
      if (belt.busy) begin
         op = (r < 78) ? OP_TICK : (r < 88) ? OP_MOVE : (r < 95) ? OP_POWER : OP_UNUSED;
      end else begin
         op = (r < 40) ? OP_TICK : (r < 72) ? OP_MOVE : (r < 95) ? OP_POWER : OP_UNUSED;
      end
      r   = $urandom_range(0, 99);
      r2  = $urandom_range(0, 99);
      pos = $signed($urandom);
      cmd = $signed($urandom);
      case (op)
         OP_TICK: begin
            if (belt.busy && r < 35) begin
               pos = belt.target + $urandom_range(0, 998) - 499;
            end else if (belt.busy && r < 45) begin
               // Exactly on the edge of the arrival window, which does not count as arrived.
               pos = belt.target + (r[0] ? 500 : -500);
            end else if (r < 75) begin
               pos = belt.target + $urandom_range(0, 200000) - 100000;
            end
         end
         OP_MOVE: begin
            if (r < 15) begin
               cmd = $urandom_range(0, 700);
            end else if (r < 55) begin
               cmd = $urandom_range(101, 20000);
            end else if (r < 80) begin
               cmd = $urandom & 32'h7FFFFFFF;
            end
            if (r2 < 60) begin
               pos = longint'($urandom_range(0, 4000)) - 2000;
            end else if (r2 < 80) begin
               pos = belt.target + $urandom_range(0, 200000) - 100000;
            end
         end
         OP_POWER: begin
            if (r < 70) begin
               cmd = $urandom_range(0, POWER_MAX);
            end else if (r < 80) begin
               cmd = r[0] ? POWER_MAX + 1 : -1;
            end
         end
         default: begin
         end
      endcase
      send_request(op, pos[31:0], cmd[31:0]);
      counted = (op != OP_UNUSED);
   endtask

   // Response side: check every accepted response, then choose the next ready level.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            belt.check_response(rsp_tdata);
         end
         if (stall > 0) begin
            stall--;
         end else begin
            stall = pick_gap(rsp_gaps_on);
         end
         rsp_tready <= (stall == 0);
      end
   end

   initial begin
      int          p;
      int          sent;
      bit          counted;
      logic [23:0] speed_max;
      logic [30:0] limit;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with the reset register values: full speed 1000000 um/s, so a
      // move runs at 500000 um/s, travel limit 1000000 um, plain moves.
      rsp_gaps_on = 1'b1;
      send_request(OP_TICK, 32'd0, 32'd0);
      send_request(OP_POWER, 32'd0, 32'd100);
      send_request(OP_TICK, 32'h7FFFFFFF, 32'd0);
      // Power values just outside the range and the most negative value are refused.
      send_request(OP_POWER, 32'd0, 32'd101);
      send_request(OP_POWER, 32'd0, 32'hFFFFFFFF);
      send_request(OP_POWER, 32'd0, 32'h80000000);
      send_request(OP_POWER, 32'd0, 32'd37);
      send_request(OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF);
      // A distance of exactly the minimum is too short; one more passes that check but lands inside the arrival window.
      send_request(OP_MOVE, 32'd0, 32'd100);
      send_request(OP_MOVE, 32'd0, 32'd101);
      // Huge distance clamps to the travel limit; ticks from both ends of the range.
      send_request(OP_MOVE, 32'd0, 32'h7FFFFFFF);
      send_request(OP_TICK, 32'h80000000, 32'd0);
      send_request(OP_TICK, 32'h7FFFFFFF, 32'd0);
      // Refused move while moving: the target still moves to 999950.
      send_request(OP_MOVE, 32'd999800, 32'd150);
      send_request(OP_TICK, 32'd999450, 32'd0);
      send_request(OP_TICK, 32'd999451, 32'd0);
      // After a move the belt stays still until the next power command.
      send_request(OP_TICK, 32'd0, 32'd0);
      // A target below zero clamps to zero.
      send_request(OP_MOVE, -32'sd5000, 32'd200);
      send_request(OP_TICK, -32'sd500, 32'd0);
      // A power command cancels the move.
      send_request(OP_POWER, 32'd0, 32'd0);
      send_request(OP_TICK, 32'd5, 32'd0);

      // Stepwise move of 5000 um in segments of at most 2000 um.
      program_registers(24'd1000000, 31'd2000, 1'b1);
      send_request(OP_MOVE, 32'd0, 32'd5000);
      send_request(OP_TICK, 32'd1999, 32'd0);
      send_request(OP_TICK, 32'd2400, 32'd0);
      send_request(OP_TICK, 32'd200, 32'd0);

      // Stepwise with no travel: every segment aims at zero and only the small
      // position errors wear the distance down.
      program_registers(24'd10000000, 31'd0, 1'b1);
      send_request(OP_MOVE, 32'd0, 32'd1000);
      send_request(OP_TICK, 32'd0, 32'd0);
      send_request(OP_TICK, 32'd499, 32'd0);
      send_request(OP_TICK, 32'hFFFFFFFF, 32'd0);

      // Random phases, each under its own register setting, extremes included.
      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: speed_max = 24'd10000000;
            1: speed_max = 24'd0;
            2: speed_max = 24'd1;
            default: speed_max = 24'($urandom_range(2, 10000000));
         endcase
         case (p % 5)
            0: limit = 31'h7FFFFFFF;
            1: limit = 31'd0;
            2: limit = 31'($urandom_range(600, 5000));
            3: limit = 31'($urandom_range(5000, 2000000));
            default: limit = 31'($urandom);
         endcase
         program_registers(speed_max, limit, p[0]);
         req_gaps_on = (p % 3 != 0);
         rsp_gaps_on = (p % 3 != 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            random_request(counted);
            if (counted) sent++;
         end
      end

      drain_responses();
      repeat (5) @(posedge clock);

      $display("Ran %0d ticks, %0d power, %0d move and %0d unused requests over %0d settings.",
               op_count[OP_TICK], op_count[OP_POWER], op_count[OP_MOVE],
               op_count[OP_UNUSED], settings_count);
      $display("The block took %0d commands and zeroed the belt %0d times.",
               belt.accepts, belt.arrivals);
      if (belt.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("Timeout with %0d responses outstanding.", belt.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
